// ----- rtl/core/sharp_pkg.sv -----
// Shared types and constants for the 3x3 sharpening stencil.
// No dependencies; used by sharp_cell, sharp_line_mem and the top level.
package sharp_pkg;

  localparam int SAMPLE_W         = 8;
  localparam int MAX_WIDTH_DEF    = 2048;
  localparam int MAX_CHANNELS_DEF = 4;

  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int CH_W       = 3;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;

  localparam int WIDTH_MIN   = 3;
  localparam int WIDTH_LIMIT = 2048;
  localparam int HEIGHT_MIN  = 3;
  localparam int HEIGHT_MAX  = 4096;
  localparam int CH_MIN      = 1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST    = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST   = 13'd480;
  localparam logic [CH_W-1:0]     CHANNELS_RST = 3'd3;

  localparam int SHARP_GAIN = 5;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;

  typedef enum logic [1:0] {
    ST_SIZE,
    ST_TOTAL,
    ST_DIV,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] up;
    logic [SAMPLE_W-1:0] mid;
    logic [SAMPLE_W-1:0] low;
  } col_t;

endpackage

// ----- rtl/core/sharp_cell.sv -----
// One window column cell: upper, middle and lower samples of one position.
// Depends on sharp_pkg (col_t).
module sharp_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  sharp_pkg::col_t   d,
  output sharp_pkg::col_t   q
);

  sharp_pkg::col_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (en) begin
      col_r <= d;
    end
  end

  assign q = col_r;

endmodule

// ----- rtl/core/sharp_line_mem.sv -----
// Line store: one write port, one registered read port.
// Depends on sharp_pkg (SAMPLE_W).
module sharp_line_mem #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [sharp_pkg::SAMPLE_W-1:0] wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [sharp_pkg::SAMPLE_W-1:0] rdata
);

  logic [sharp_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [sharp_pkg::SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/sharp_div.sv -----
// Restoring divider, one quotient bit per cycle; splits a sample position
// into row and column. Depends on nothing beyond its parameters.
module sharp_div #(
  parameter int DW = 26,
  parameter int VW = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quo_r;
  logic [VW-1:0]   rem_r;
  logic [VW-1:0]   dvs_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [VW:0]     shifted;
  logic [VW:0]     diff;
  logic            fits;

  assign shifted = {rem_r, quo_r[DW-1]};
  assign fits    = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNTW'(1);
      if (cnt_r == CNTW'(DW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[VW-1:0] : shifted[VW-1:0];
      quo_r <= {quo_r[DW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/core/sharpen_3x3_stencil.sv -----
// Top level of the 3x3 sharpening stencil: position control, line stores,
// window cell chain and output register. Depends on sharp_pkg, sharp_cell,
// sharp_line_mem and sharp_div.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+-----------
//   in      | in_valid in_stall in_mode in_sample | into block
//   out     | out_valid out_stall out_value       | out of block
//           | out_frame_end                       |
//   cfg     | cfg_we cfg_index cfg_data           | into block
//
// One transaction per cycle in both directions while in_stall and out_stall are low; an
// accepted transaction passes the line-store stage and then the output register.
// After reset and after every cfg write the sizes are recomputed and the row/column of
// the frame position is rebuilt by a bit-serial divider; in_stall is high until this
// is done. A stalled output holds the whole pipe.
module sharpen_3x3_stencil #(
  parameter int MAX_WIDTH    = sharp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_CHANNELS = sharp_pkg::MAX_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [sharp_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sharp_pkg::SAMPLE_W-1:0]  out_value,
  output logic                            out_frame_end,
  input  logic                            cfg_we,
  input  logic [sharp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sharp_pkg::CFG_W-1:0]     cfg_data
);

  localparam int WHI = (MAX_WIDTH < sharp_pkg::WIDTH_LIMIT) ? MAX_WIDTH
                                                            : sharp_pkg::WIDTH_LIMIT;
  localparam int LINE_DEPTH = WHI * MAX_CHANNELS;
  localparam int AW    = $clog2(LINE_DEPTH);
  localparam int RLW   = $clog2(LINE_DEPTH + 1);
  localparam int CW    = RLW + 1;
  localparam int PW    = $clog2(LINE_DEPTH * sharp_pkg::HEIGHT_MAX + 1);
  localparam int RW    = sharp_pkg::HEIGHT_W;
  localparam int NCELL = 2 * MAX_CHANNELS;
  localparam int TW    = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int SW    = sharp_pkg::SAMPLE_W;
  localparam int VW    = SW + 3;

  // configuration and derived sizes
  logic [sharp_pkg::WIDTH_W-1:0]  width_r;
  logic [sharp_pkg::HEIGHT_W-1:0] height_r;
  logic [sharp_pkg::CH_W-1:0]     chan_r;
  logic [sharp_pkg::WIDTH_W-1:0]  w_eff;
  logic [sharp_pkg::HEIGHT_W-1:0] rows_eff;
  logic [sharp_pkg::CH_W-1:0]     ch_eff;

  logic [sharp_pkg::CH_W-1:0]     ch_r;
  logic [RW-1:0]                  rows_r;
  logic [RW-1:0]                  rows_m1_r;
  logic [RLW-1:0]                 rowlen_r;
  logic [RLW-1:0]                 rin_r;
  logic [PW-1:0]                  total_r;
  logic [PW-1:0]                  lag_r;

  sharp_pkg::state_t state_r, state_nxt;

  // positions
  logic [PW-1:0] p_r;
  logic [PW-1:0] outp_r;
  logic [RW-1:0] r_r;
  logic [AW-1:0] c_r;

  logic          div_done;
  logic [PW-1:0] div_quo;
  logic [RLW-1:0] div_rem;

  // accept stage
  logic          adv;
  logic          acc;
  logic          take_data;
  logic          take_drain;
  logic          p_lt;
  logic          c_ge;
  logic [CW-1:0] qc;
  logic [RW-1:0] qr;
  logic          inner;
  logic          col_last;
  logic          emit_d;
  logic [PW-1:0] outp_inc;
  logic          last_d;

  // line-store stage
  logic          s1_v_r;
  logic          s1_shift_r;
  logic          s1_emit_r;
  logic          s1_inner_r;
  logic          s1_fe_r;
  logic          s1_gup_r;
  logic          s1_gmid_r;
  logic [SW-1:0] s1_sample_r;
  logic [AW-1:0] s1_addr_r;
  logic          s1_go;
  logic          shift_en;
  logic [SW-1:0] up_rd;
  logic [SW-1:0] mid_rd;
  logic [SW-1:0] up_v;
  logic [SW-1:0] mid_v;

  sharp_pkg::col_t cell_d [NCELL];
  sharp_pkg::col_t cell_q [NCELL];

  logic [TW-1:0] idx_a;
  logic [TW-1:0] idx_b;
  logic [VW-1:0] pos_sum;
  logic [VW-1:0] neg_sum;
  logic [VW-1:0] diff;
  logic [SW-1:0] sharp_v;

  logic          out_valid_r;
  logic [SW-1:0] out_value_r;
  logic          out_fe_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sharp_pkg::WIDTH_RST;
      height_r <= sharp_pkg::HEIGHT_RST;
      chan_r   <= sharp_pkg::CHANNELS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sharp_pkg::REG_WIDTH:    width_r  <= cfg_data[sharp_pkg::WIDTH_W-1:0];
        sharp_pkg::REG_HEIGHT:   height_r <= cfg_data[sharp_pkg::HEIGHT_W-1:0];
        sharp_pkg::REG_CHANNELS: chan_r   <= cfg_data[sharp_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = width_r;
    if (width_r < sharp_pkg::WIDTH_W'(sharp_pkg::WIDTH_MIN)) begin
      w_eff = sharp_pkg::WIDTH_W'(sharp_pkg::WIDTH_MIN);
    end else if (width_r > sharp_pkg::WIDTH_W'(WHI)) begin
      w_eff = sharp_pkg::WIDTH_W'(WHI);
    end
    rows_eff = height_r;
    if (height_r < sharp_pkg::HEIGHT_W'(sharp_pkg::HEIGHT_MIN)) begin
      rows_eff = sharp_pkg::HEIGHT_W'(sharp_pkg::HEIGHT_MIN);
    end else if (height_r > sharp_pkg::HEIGHT_W'(sharp_pkg::HEIGHT_MAX)) begin
      rows_eff = sharp_pkg::HEIGHT_W'(sharp_pkg::HEIGHT_MAX);
    end
    ch_eff = chan_r;
    if (chan_r < sharp_pkg::CH_W'(sharp_pkg::CH_MIN)) begin
      ch_eff = sharp_pkg::CH_W'(sharp_pkg::CH_MIN);
    end else if (chan_r > sharp_pkg::CH_W'(MAX_CHANNELS)) begin
      ch_eff = sharp_pkg::CH_W'(MAX_CHANNELS);
    end
  end

  // ------------------------------------------------------- size sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sharp_pkg::ST_SIZE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (cfg_we) begin
      state_nxt = sharp_pkg::ST_SIZE;
    end else begin
      unique case (state_r)
        sharp_pkg::ST_SIZE:  state_nxt = sharp_pkg::ST_TOTAL;
        sharp_pkg::ST_TOTAL: state_nxt = sharp_pkg::ST_DIV;
        sharp_pkg::ST_DIV:   if (div_done) state_nxt = sharp_pkg::ST_RUN;
        sharp_pkg::ST_RUN:   state_nxt = sharp_pkg::ST_RUN;
        default:             state_nxt = sharp_pkg::ST_SIZE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sharp_pkg::ST_SIZE) begin
      ch_r      <= ch_eff;
      rows_r    <= rows_eff;
      rows_m1_r <= rows_eff - RW'(1);
      rowlen_r  <= RLW'(w_eff * ch_eff);
    end
    if (state_r == sharp_pkg::ST_TOTAL) begin
      total_r <= PW'(rowlen_r * rows_r);
      lag_r   <= PW'(rowlen_r) + PW'(ch_r);
      rin_r   <= rowlen_r - RLW'(ch_r);
    end
  end

  sharp_div #(
    .DW(PW),
    .VW(RLW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == sharp_pkg::ST_TOTAL),
    .dividend (p_r),
    .divisor  (rowlen_r),
    .done     (div_done),
    .quot     (div_quo),
    .rem      (div_rem)
  );

  // ---------------------------------------------------------- accept stage
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv || (state_r != sharp_pkg::ST_RUN) || cfg_we;
  assign acc      = in_valid && !in_stall;

  assign p_lt       = p_r < total_r;
  assign take_data  = acc && !in_mode && p_lt;
  assign take_drain = acc && in_mode && !p_lt;

  assign c_ge     = CW'(c_r) >= CW'(ch_r);
  assign qc       = c_ge ? (CW'(c_r) - CW'(ch_r))
                         : (CW'(c_r) + CW'(rowlen_r) - CW'(ch_r));
  assign qr       = c_ge ? (r_r - RW'(1)) : (r_r - RW'(2));
  assign inner    = (qr != '0) && (qr != rows_m1_r) &&
                    (qc >= CW'(ch_r)) && (qc < CW'(rin_r));
  assign col_last = (CW'(c_r) + CW'(1)) == CW'(rowlen_r);
  assign emit_d   = p_r >= lag_r;
  assign outp_inc = outp_r + PW'(1);
  assign last_d   = outp_inc >= total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r    <= '0;
      outp_r <= '0;
      r_r    <= '0;
      c_r    <= '0;
    end else if ((state_r == sharp_pkg::ST_DIV) && div_done) begin
      r_r <= div_quo[RW-1:0];
      c_r <= div_rem[AW-1:0];
    end else if (take_data) begin
      p_r <= p_r + PW'(1);
      if (emit_d) begin
        outp_r <= p_r - lag_r + PW'(1);
      end
      if (col_last) begin
        c_r <= '0;
        r_r <= r_r + RW'(1);
      end else begin
        c_r <= c_r + AW'(1);
      end
    end else if (take_drain) begin
      if (last_d) begin
        p_r    <= '0;
        outp_r <= '0;
        r_r    <= '0;
        c_r    <= '0;
      end else begin
        outp_r <= outp_inc;
      end
    end
  end

  // ------------------------------------------------------ line-store stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= take_data || take_drain;
    end
  end

  always_ff @(posedge clk) begin
    if (take_data || take_drain) begin
      s1_shift_r  <= take_data;
      s1_emit_r   <= take_drain || emit_d;
      s1_inner_r  <= take_data && inner;
      s1_fe_r     <= take_drain && last_d;
      s1_gup_r    <= r_r >= RW'(2);
      s1_gmid_r   <= r_r != '0;
      s1_sample_r <= in_sample;
      s1_addr_r   <= c_r;
    end
  end

  assign s1_go    = s1_v_r && adv;
  assign shift_en = s1_go && s1_shift_r;

  sharp_line_mem #(
    .DEPTH(LINE_DEPTH),
    .AW   (AW)
  ) u_upper (
    .clk   (clk),
    .we    (shift_en),
    .waddr (s1_addr_r),
    .wdata (mid_v),
    .re    (take_data),
    .raddr (c_r),
    .rdata (up_rd)
  );

  sharp_line_mem #(
    .DEPTH(LINE_DEPTH),
    .AW   (AW)
  ) u_middle (
    .clk   (clk),
    .we    (shift_en),
    .waddr (s1_addr_r),
    .wdata (s1_sample_r),
    .re    (take_data),
    .raddr (c_r),
    .rdata (mid_rd)
  );

  assign up_v  = s1_gup_r  ? up_rd  : '0;
  assign mid_v = s1_gmid_r ? mid_rd : '0;

  // window: cell k holds the column k+1 places back, before this shift
  assign cell_d[0] = '{up: up_v, mid: mid_v, low: s1_sample_r};

  for (genvar k = 1; k < NCELL; k++) begin : g_link
    assign cell_d[k] = cell_q[k-1];
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    sharp_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (shift_en),
      .d     (cell_d[k]),
      .q     (cell_q[k])
    );
  end

  assign idx_a = TW'(ch_r - sharp_pkg::CH_W'(1));
  assign idx_b = TW'({1'b0, ch_r, 1'b0} - 5'd1);

  assign pos_sum = VW'(sharp_pkg::SHARP_GAIN) * VW'(cell_q[idx_a].mid);
  assign neg_sum = VW'(cell_q[idx_b].mid) + VW'(mid_v) +
                   VW'(cell_q[idx_a].up)  + VW'(cell_q[idx_a].low);
  assign diff    = pos_sum - neg_sum;

  always_comb begin
    if (neg_sum > pos_sum) begin
      sharp_v = '0;
    end else if (diff > VW'(2**SW - 1)) begin
      sharp_v = '1;
    end else begin
      sharp_v = diff[SW-1:0];
    end
  end

  // --------------------------------------------------------- output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit_r) begin
      out_value_r <= s1_inner_r ? sharp_v : '0;
      out_fe_r    <= s1_fe_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_frame_end = out_fe_r;

  // ------------------------------------------------------------ assertions
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sharp_pkg::ST_RUN) |-> (CW'(c_r) < CW'(rowlen_r)))
    else $error("column position beyond row length");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == sharp_pkg::ST_RUN) && (p_r < total_r)) |-> (r_r < rows_r))
    else $error("row position beyond frame height");

  a_frame_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> (out_value == '0))
    else $error("frame end transaction carries non-zero value");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (take_drain && last_d) |=> ((p_r == '0) && (outp_r == '0) && (c_r == '0)))
    else $error("positions not cleared after last drain");

endmodule
